@@ design/bspseg_pkg.sv @@
package bspseg_pkg;

    localparam int FRAC_BITS = 16;
    localparam int COORD_W = 32;
    localparam int DIFF_W = COORD_W + 1;
    localparam int MAG_W = COORD_W;
    localparam int PROD_W = DIFF_W + COORD_W;
    localparam int CROSS_W = PROD_W + 1;
    localparam int DEN_W = CROSS_W + 1;
    localparam int ANUM_W = CROSS_W - 1;
    localparam int AD_W = DEN_W - 1;
    localparam int PLO_W = 33;
    localparam int PP_W = ANUM_W + MAG_W;
    localparam int NUM_W = PP_W + 2;
    localparam int DIV_W = AD_W + 1;
    localparam int QUO_W = MAG_W + 1;
    localparam int CMP_W = DIV_W + QUO_W;
    localparam int RES_W = COORD_W + 3;
    localparam int EPS_SH = 2 * FRAC_BITS - 7;

    localparam logic signed [CROSS_W-1:0] EPS = CROSS_W'(1) << EPS_SH;
    localparam logic signed [DEN_W-1:0] EPS_DEN = DEN_W'(1) << EPS_SH;

    typedef enum logic [1:0] {
        CFG_LINE_POINT_X = 2'd0,
        CFG_LINE_POINT_Y = 2'd1,
        CFG_LINE_DIR_X   = 2'd2,
        CFG_LINE_DIR_Y   = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        PLACE_BACK  = 2'd0,
        PLACE_FRONT = 2'd1,
        PLACE_SPLIT = 2'd2
    } t_place;

    typedef enum logic [1:0] {
        SIDE_BACK  = 2'd0,
        SIDE_FRONT = 2'd1,
        SIDE_ON    = 2'd2
    } t_side_code;

    // per-item sideband that rides along the divider
    typedef struct packed {
        t_place                      place;
        logic                        interp;
        logic                        neg_x;
        logic                        neg_y;
        logic signed [COORD_W-1:0]   px;
        logic signed [COORD_W-1:0]   py;
    } t_side;

    function automatic t_side_code side_of(input logic signed [CROSS_W-1:0] d);
        t_side_code s;
        if (d > EPS) s = SIDE_FRONT;
        else if (d < -EPS) s = SIDE_BACK;
        else s = SIDE_ON;
        return s;
    endfunction

endpackage

@@ design/bspseg_div.sv @@
module bspseg_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  bspseg_pkg::t_side                   i_side,
    input  logic [bspseg_pkg::NUM_W-1:0]        i_num_x,
    input  logic [bspseg_pkg::NUM_W-1:0]        i_num_y,
    input  logic [bspseg_pkg::DIV_W-1:0]        i_den,
    output logic                                o_valid,
    output bspseg_pkg::t_side                   o_side,
    output logic [bspseg_pkg::QUO_W-1:0]        o_quo_x,
    output logic [bspseg_pkg::QUO_W-1:0]        o_quo_y
);

    localparam int QW = bspseg_pkg::QUO_W;
    localparam int NW = bspseg_pkg::NUM_W;
    localparam int DW = bspseg_pkg::DIV_W;
    localparam int CW = bspseg_pkg::CMP_W;

    logic                 r_v    [1:QW];
    bspseg_pkg::t_side    r_side [1:QW];
    logic [NW-1:0]        r_rx   [1:QW];
    logic [NW-1:0]        r_ry   [1:QW];
    logic [DW-1:0]        r_dv   [1:QW];
    logic [QW-1:0]        r_qx   [1:QW];
    logic [QW-1:0]        r_qy   [1:QW];

    logic                 w_v    [0:QW];
    bspseg_pkg::t_side    w_side [0:QW];
    logic [NW-1:0]        w_rx   [0:QW];
    logic [NW-1:0]        w_ry   [0:QW];
    logic [DW-1:0]        w_dv   [0:QW];
    logic [QW-1:0]        w_qx   [0:QW];
    logic [QW-1:0]        w_qy   [0:QW];

    assign w_v[0]    = i_valid;
    assign w_side[0] = i_side;
    assign w_rx[0]   = i_num_x;
    assign w_ry[0]   = i_num_y;
    assign w_dv[0]   = i_den;
    assign w_qx[0]   = '0;
    assign w_qy[0]   = '0;

    for (genvar j = 0; j < QW; j++) begin : g_stage
        localparam int SH = QW - 1 - j;
        logic [CW-1:0] dsh;
        logic [CW-1:0] rx_ext;
        logic [CW-1:0] ry_ext;
        logic          ge_x;
        logic          ge_y;
        logic [NW-1:0] n_rx;
        logic [NW-1:0] n_ry;

        assign w_v[j+1]    = r_v[j+1];
        assign w_side[j+1] = r_side[j+1];
        assign w_rx[j+1]   = r_rx[j+1];
        assign w_ry[j+1]   = r_ry[j+1];
        assign w_dv[j+1]   = r_dv[j+1];
        assign w_qx[j+1]   = r_qx[j+1];
        assign w_qy[j+1]   = r_qy[j+1];

        // one quotient bit per stage, divisor pre-shifted to this bit weight
        assign dsh    = CW'(w_dv[j]) << SH;
        assign rx_ext = CW'(w_rx[j]);
        assign ry_ext = CW'(w_ry[j]);
        assign ge_x   = rx_ext >= dsh;
        assign ge_y   = ry_ext >= dsh;
        assign n_rx   = ge_x ? NW'(rx_ext - dsh) : w_rx[j];
        assign n_ry   = ge_y ? NW'(ry_ext - dsh) : w_ry[j];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j+1] <= 1'b0;
            end else if (i_en) begin
                r_v[j+1] <= w_v[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[j+1] <= w_side[j];
                r_rx[j+1]   <= n_rx;
                r_ry[j+1]   <= n_ry;
                r_dv[j+1]   <= w_dv[j];
                r_qx[j+1]   <= {w_qx[j][QW-2:0], ge_x};
                r_qy[j+1]   <= {w_qy[j][QW-2:0], ge_y};
            end
        end
    end

    assign o_valid = w_v[QW];
    assign o_side  = w_side[QW];
    assign o_quo_x = w_qx[QW];
    assign o_quo_y = w_qy[QW];

endmodule

@@ design/bsp_seg_partition_classifier.sv @@
// channel  | direction | handshake                  | payload
// ---------+-----------+----------------------------+----------------------------------
// in       | input     | i_in_valid / o_in_ready    | i_start_x/y, i_end_x/y
// out      | output    | o_out_valid / i_out_ready  | o_placement, o_cross_x/y
// cfg      | input     | i_cfg_we (no wait)         | i_cfg_idx, i_cfg_data
//
// one item per cycle sustained while the output is not stalled; 41 register stages
// those stages are the 33-stage restoring divider (one quotient bit per stage)
// plus seven arithmetic stages and the output register
// reset is synchronous, active low, clears valid bits and line registers
// a stall at the output freezes the whole pipeline; o_in_ready follows it
module bsp_seg_partition_classifier (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_in_valid,
    output logic                                        o_in_ready,
    input  logic signed [bspseg_pkg::COORD_W-1:0]       i_start_x,
    input  logic signed [bspseg_pkg::COORD_W-1:0]       i_start_y,
    input  logic signed [bspseg_pkg::COORD_W-1:0]       i_end_x,
    input  logic signed [bspseg_pkg::COORD_W-1:0]       i_end_y,
    output logic                                        o_out_valid,
    input  logic                                        i_out_ready,
    output logic [1:0]                                  o_placement,
    output logic signed [bspseg_pkg::COORD_W-1:0]       o_cross_x,
    output logic signed [bspseg_pkg::COORD_W-1:0]       o_cross_y,
    input  logic                                        i_cfg_we,
    input  logic [1:0]                                  i_cfg_idx,
    input  logic [bspseg_pkg::COORD_W-1:0]              i_cfg_data
);

    localparam int CO = bspseg_pkg::COORD_W;
    localparam int DF = bspseg_pkg::DIFF_W;
    localparam int MG = bspseg_pkg::MAG_W;
    localparam int PR = bspseg_pkg::PROD_W;
    localparam int CR = bspseg_pkg::CROSS_W;
    localparam int DN = bspseg_pkg::DEN_W;
    localparam int AN = bspseg_pkg::ANUM_W;
    localparam int AD = bspseg_pkg::AD_W;
    localparam int PL = bspseg_pkg::PLO_W;
    localparam int PP = bspseg_pkg::PP_W;
    localparam int NW = bspseg_pkg::NUM_W;
    localparam int DW = bspseg_pkg::DIV_W;
    localparam int QW = bspseg_pkg::QUO_W;
    localparam int RW = bspseg_pkg::RES_W;

    // line registers
    logic signed [CO-1:0] r_lpx, r_lpy, r_ldx, r_ldy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lpx <= '0;
            r_lpy <= '0;
            r_ldx <= '0;
            r_ldy <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bspseg_pkg::CFG_LINE_POINT_X: r_lpx <= i_cfg_data;
                bspseg_pkg::CFG_LINE_POINT_Y: r_lpy <= i_cfg_data;
                bspseg_pkg::CFG_LINE_DIR_X:   r_ldx <= i_cfg_data;
                bspseg_pkg::CFG_LINE_DIR_Y:   r_ldy <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // global advance: everything moves unless a finished result is stuck
    logic w_en;
    assign w_en       = !o_out_valid || i_out_ready;
    assign o_in_ready = w_en;

    // stage 1: offsets from line origin, segment delta magnitudes
    logic                  r1_v;
    logic signed [CO-1:0]  r1_ax, r1_ay, r1_bx, r1_by;
    logic signed [DF-1:0]  r1_ex1, r1_ey1, r1_ex2, r1_ey2;
    logic [MG-1:0]         r1_kx, r1_ky;
    logic                  r1_knx, r1_kny;
    logic signed [DF-1:0]  n_dlx, n_dly;

    assign n_dlx = DF'(i_end_x) - DF'(i_start_x);
    assign n_dly = DF'(i_end_y) - DF'(i_start_y);

    // stage 2: cross product terms
    logic                  r2_v;
    logic signed [CO-1:0]  r2_ax, r2_ay, r2_bx, r2_by;
    logic signed [PR-1:0]  r2_m1a, r2_m1b, r2_m2a, r2_m2b;
    logic [MG-1:0]         r2_kx, r2_ky;
    logic                  r2_knx, r2_kny;

    // stage 3: signed distances of both endpoints
    logic                  r3_v;
    logic signed [CO-1:0]  r3_ax, r3_ay, r3_bx, r3_by;
    logic signed [CR-1:0]  r3_d1, r3_d2;
    logic [MG-1:0]         r3_kx, r3_ky;
    logic                  r3_knx, r3_kny;

    // stage 4: sides, denominator, numerator magnitude
    logic                          r4_v;
    logic signed [CO-1:0]          r4_ax, r4_ay, r4_bx, r4_by;
    bspseg_pkg::t_side_code        r4_s1, r4_s2;
    logic signed [DN-1:0]          r4_den;
    logic [AN-1:0]                 r4_an;
    logic                          r4_d1neg;
    logic [MG-1:0]                 r4_kx, r4_ky;
    logic                          r4_knx, r4_kny;
    logic signed [CR-1:0]          n_d1neg;

    assign n_d1neg = -r3_d1;

    // stage 5: classification and split partial products
    logic                  r5_v;
    bspseg_pkg::t_side     r5_side;
    logic [AD-1:0]         r5_ad;
    logic [PL+MG-1:0]      r5_plx, r5_ply;
    logic [AN-PL+MG-1:0]   r5_phx, r5_phy;
    bspseg_pkg::t_side     n_side;
    logic                  n_par;
    logic                  n_numneg;
    logic signed [DN-1:0]  n_denneg;

    assign n_par    = (r4_den < bspseg_pkg::EPS_DEN) && (r4_den > -bspseg_pkg::EPS_DEN);
    assign n_numneg = !r4_d1neg;
    assign n_denneg = -r4_den;

    always_comb begin
        n_side        = '0;
        n_side.place  = bspseg_pkg::PLACE_FRONT;
        n_side.neg_x  = r4_knx ^ n_numneg ^ r4_den[DN-1];
        n_side.neg_y  = r4_kny ^ n_numneg ^ r4_den[DN-1];
        if (r4_s1 == r4_s2) begin
            // both on one side, or both on the line
            n_side.place = (r4_s1 == bspseg_pkg::SIDE_BACK) ? bspseg_pkg::PLACE_BACK
                                                            : bspseg_pkg::PLACE_FRONT;
        end else if (n_par) begin
            n_side.place = bspseg_pkg::PLACE_FRONT;
        end else begin
            n_side.place = bspseg_pkg::PLACE_SPLIT;
            if (r4_s1 == bspseg_pkg::SIDE_ON) begin
                n_side.px = r4_ax;
                n_side.py = r4_ay;
            end else if (r4_s2 == bspseg_pkg::SIDE_ON) begin
                n_side.px = r4_bx;
                n_side.py = r4_by;
            end else begin
                // proper crossing, interpolate from start point
                n_side.interp = 1'b1;
                n_side.px     = r4_ax;
                n_side.py     = r4_ay;
            end
        end
    end

    // stage 6: full product
    logic                  r6_v;
    bspseg_pkg::t_side     r6_side;
    logic [AD-1:0]         r6_ad;
    logic [PP-1:0]         r6_px, r6_py;

    // stage 7: rounded dividend and doubled divisor
    logic                  r7_v;
    bspseg_pkg::t_side     r7_side;
    logic [NW-1:0]         r7_nx, r7_ny;
    logic [DW-1:0]         r7_dv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
            r6_v <= 1'b0;
            r7_v <= 1'b0;
        end else if (w_en) begin
            r1_v <= i_in_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
            r6_v <= r5_v;
            r7_v <= r6_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_ax  <= i_start_x;
            r1_ay  <= i_start_y;
            r1_bx  <= i_end_x;
            r1_by  <= i_end_y;
            r1_ex1 <= DF'(i_start_x) - DF'(r_lpx);
            r1_ey1 <= DF'(i_start_y) - DF'(r_lpy);
            r1_ex2 <= DF'(i_end_x) - DF'(r_lpx);
            r1_ey2 <= DF'(i_end_y) - DF'(r_lpy);
            r1_kx  <= n_dlx[DF-1] ? MG'(-n_dlx) : n_dlx[MG-1:0];
            r1_ky  <= n_dly[DF-1] ? MG'(-n_dly) : n_dly[MG-1:0];
            r1_knx <= n_dlx[DF-1];
            r1_kny <= n_dly[DF-1];

            r2_ax  <= r1_ax;
            r2_ay  <= r1_ay;
            r2_bx  <= r1_bx;
            r2_by  <= r1_by;
            r2_m1a <= r1_ex1 * r_ldy;
            r2_m1b <= r1_ey1 * r_ldx;
            r2_m2a <= r1_ex2 * r_ldy;
            r2_m2b <= r1_ey2 * r_ldx;
            r2_kx  <= r1_kx;
            r2_ky  <= r1_ky;
            r2_knx <= r1_knx;
            r2_kny <= r1_kny;

            r3_ax  <= r2_ax;
            r3_ay  <= r2_ay;
            r3_bx  <= r2_bx;
            r3_by  <= r2_by;
            r3_d1  <= CR'(r2_m1a) - CR'(r2_m1b);
            r3_d2  <= CR'(r2_m2a) - CR'(r2_m2b);
            r3_kx  <= r2_kx;
            r3_ky  <= r2_ky;
            r3_knx <= r2_knx;
            r3_kny <= r2_kny;

            r4_ax    <= r3_ax;
            r4_ay    <= r3_ay;
            r4_bx    <= r3_bx;
            r4_by    <= r3_by;
            r4_s1    <= bspseg_pkg::side_of(r3_d1);
            r4_s2    <= bspseg_pkg::side_of(r3_d2);
            r4_den   <= DN'(r3_d2) - DN'(r3_d1);
            r4_an    <= r3_d1[CR-1] ? n_d1neg[AN-1:0] : r3_d1[AN-1:0];
            r4_d1neg <= r3_d1[CR-1];
            r4_kx    <= r3_kx;
            r4_ky    <= r3_ky;
            r4_knx   <= r3_knx;
            r4_kny   <= r3_kny;

            r5_side <= n_side;
            r5_ad   <= r4_den[DN-1] ? n_denneg[AD-1:0] : r4_den[AD-1:0];
            r5_plx  <= r4_an[PL-1:0] * r4_kx;
            r5_ply  <= r4_an[PL-1:0] * r4_ky;
            r5_phx  <= r4_an[AN-1:PL] * r4_kx;
            r5_phy  <= r4_an[AN-1:PL] * r4_ky;

            r6_side <= r5_side;
            r6_ad   <= r5_ad;
            r6_px   <= PP'(r5_plx) + (PP'(r5_phx) << PL);
            r6_py   <= PP'(r5_ply) + (PP'(r5_phy) << PL);

            // round to nearest: (2*p + den) / (2*den)
            r7_side <= r6_side;
            r7_nx   <= (NW'(r6_px) << 1) + NW'(r6_ad);
            r7_ny   <= (NW'(r6_py) << 1) + NW'(r6_ad);
            r7_dv   <= DW'(r6_ad) << 1;
        end
    end

    logic                  w_dv_v;
    bspseg_pkg::t_side     w_dv_side;
    logic [QW-1:0]         w_qx, w_qy;

    bspseg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r7_v),
        .i_side  (r7_side),
        .i_num_x (r7_nx),
        .i_num_y (r7_ny),
        .i_den   (r7_dv),
        .o_valid (w_dv_v),
        .o_side  (w_dv_side),
        .o_quo_x (w_qx),
        .o_quo_y (w_qy)
    );

    // final offset and saturation
    logic signed [RW-1:0] n_rx, n_ry;
    logic signed [CO-1:0] n_cx, n_cy;

    assign n_rx = w_dv_side.neg_x ? RW'(w_dv_side.px) - $signed(RW'(w_qx))
                                  : RW'(w_dv_side.px) + $signed(RW'(w_qx));
    assign n_ry = w_dv_side.neg_y ? RW'(w_dv_side.py) - $signed(RW'(w_qy))
                                  : RW'(w_dv_side.py) + $signed(RW'(w_qy));

    always_comb begin
        n_cx = w_dv_side.px;
        n_cy = w_dv_side.py;
        if (w_dv_side.interp) begin
            if (n_rx > RW'($signed({1'b0, {(CO-1){1'b1}}})))
                n_cx = {1'b0, {(CO-1){1'b1}}};
            else if (n_rx < RW'($signed({1'b1, {(CO-1){1'b0}}})))
                n_cx = {1'b1, {(CO-1){1'b0}}};
            else
                n_cx = n_rx[CO-1:0];
            if (n_ry > RW'($signed({1'b0, {(CO-1){1'b1}}})))
                n_cy = {1'b0, {(CO-1){1'b1}}};
            else if (n_ry < RW'($signed({1'b1, {(CO-1){1'b0}}})))
                n_cy = {1'b1, {(CO-1){1'b0}}};
            else
                n_cy = n_ry[CO-1:0];
        end
    end

    logic r_out_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_en) begin
            r_out_v <= w_dv_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            o_placement <= w_dv_side.place;
            o_cross_x   <= n_cx;
            o_cross_y   <= n_cy;
        end
    end

    assign o_out_valid = r_out_v;

    // non-split results carry no crossing point
    a_nonsplit_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_placement != bspseg_pkg::PLACE_SPLIT)
        |-> (o_cross_x == '0) && (o_cross_y == '0))
        else $error("crossing point set on a non-split item");

    // an empty output register never blocks the input
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output");

    // nothing comes out right after reset
    a_reset_clears: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("output valid after reset");

    // a stalled result holds its placement
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_placement))
        else $error("stalled item changed");

endmodule
